FILE: hdl/itoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths, constants, types and the digit-to-character function of the
// integer-to-ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_BITS    = 31;
	localparam int MAX_DIGITS    = 32;
	localparam int RADIX_W       = 6;
	localparam int DIGIT_W       = 6;
	localparam int CHAR_W        = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

	// Quotient bits resolved per divider cycle.
	localparam int BITS_PER_STEP = 8;
	localparam int DIV_STEPS     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
	localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W         = $clog2(MAX_DIGITS);

	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(65);
	localparam logic [DIGIT_W-1:0] DEC_MAX   = DIGIT_W'(9);
	localparam logic [CHAR_W-1:0]  DEC_BASE  = CHAR_W'(10);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_W-1:0]    base;
	} itoa_job_t;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] offs;
		offs = (d > DEC_MAX) ? (CHAR_A - DEC_BASE) : CHAR_ZERO;
		return CHAR_W'(d) + offs;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/integer_to_ascii_radix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts non-negative integers to ASCII digit strings in a programmable
// base, most significant digit first, last character flagged.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low; a two-entry queue holds
// values waiting for the converter, and busy is high only while it is full.
// Each character comes out as one beat with result_valid high for exactly one
// cycle; the receiver cannot stall, so it must take every beat as it appears.
// A value of n digits occupies the converter for one pass of the shared
// restoring divider per digit (eight quotient bits per cycle over a 32-bit
// dividend) and one digit-store read per character. The radix must be
// written through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this. Values below two act as two and values above
// 36 act as 36.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [itoa_pkg::RADIX_W-1:0]      cfg_wdata,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [itoa_pkg::VALUE_BITS-1:0]   value,
	output logic                                   result_valid,
	output logic [itoa_pkg::CHAR_W-1:0]            digit_char,
	output logic                                   last_digit
);
	import itoa_pkg::*;

	itoa_job_t push_job;
	itoa_job_t pop_job;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	itoa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.value     (value),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (push_job)
	);

	itoa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_job),
		.pop    (q_pop),
		.rdata  (pop_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	itoa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_rdata      (pop_job),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.digit_char   (digit_char),
		.last_digit   (last_digit)
	);

	assign busy = q_full;

	// Every emitted character is a decimal digit or an upper-case letter.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((digit_char >= CHAR_ZERO && digit_char <= CHAR_W'(57)) ||
			(digit_char >= CHAR_A && digit_char <= CHAR_W'(90))))
		else $error("digit_char outside 0-9 and A-Z");

	// The next number needs at least one divider pass, so a gap follows the last beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_digit) |=> !result_valid)
		else $error("beat directly after the last character of a number");

	// The queue fills only through an accepted value.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted value");

	// last_digit only ever marks a real beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		last_digit |-> result_valid)
		else $error("last_digit without result_valid");

endmodule
`default_nettype wire

FILE: hdl/itoa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_front
// Holds the radix register, accepts input values and pushes each one with its
// clamped radix into the job queue.
// ----------------------------------------------------------------------------
module itoa_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [itoa_pkg::RADIX_W-1:0]  cfg_wdata,
	input  wire logic                          start,
	input  wire logic [itoa_pkg::VALUE_BITS-1:0] value,
	input  wire logic                          q_full,
	output logic                               q_push,
	output itoa_pkg::itoa_job_t                q_wdata
);
	import itoa_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Bases below two would never terminate; bases above 36 run out of letters.
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	assign q_push        = start && !q_full;
	assign q_wdata.value = value;
	assign q_wdata.base  = base;

endmodule
`default_nettype wire

FILE: hdl/itoa_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_queue
// Short job queue between the front and the back, so that a new value can be
// taken while the previous one is still being converted.
// ----------------------------------------------------------------------------
module itoa_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire itoa_pkg::itoa_job_t  wdata,
	input  wire logic                 pop,
	output itoa_pkg::itoa_job_t       rdata,
	output logic                      full,
	output logic                      empty
);
	import itoa_pkg::*;

	itoa_job_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/itoa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_back
// Converts one job: repeated division by the radix in a multi-cycle restoring
// divider, remainders kept in the digit store, then the digits read back most
// significant first and sent out as ASCII characters.
// ----------------------------------------------------------------------------
module itoa_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_empty,
	input  wire itoa_pkg::itoa_job_t       q_rdata,
	output logic                           q_pop,
	output logic                           result_valid,
	output logic [itoa_pkg::CHAR_W-1:0]    digit_char,
	output logic                           last_digit
);
	import itoa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]          state_q;
	logic [DIV_W-1:0]    work_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  base_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    rd_idx_q;

	logic [DIGIT_W-1:0]  digit_store [MAX_DIGITS];
	logic [DIGIT_W-1:0]  rd_digit_s1;
	logic                rd_valid_s1;
	logic                rd_last_s1;

	logic [DIV_W-1:0]    work_n;
	logic [DIGIT_W-1:0]  rem_n;
	logic                last_step;
	logic                div_done;
	logic                store_we;

	// One divider cycle resolves BITS_PER_STEP quotient bits, shifting them into
	// the low end of the working register as the dividend leaves the top.
	always_comb begin
		logic [DIGIT_W:0]   trial;
		logic [DIGIT_W-1:0] r;
		logic [DIV_W-1:0]   w;
		r = rem_q;
		w = work_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			trial = {r, w[DIV_W-1]};
			w     = {w[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, base_q}) begin
				trial = trial - {1'b0, base_q};
				w[0]  = 1'b1;
			end
			r = trial[DIGIT_W-1:0];
		end
		rem_n  = r;
		work_n = w;
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));
	assign store_we  = (state_q == ST_DIV) && last_step;
	// A zero quotient ends the digits; a zero input thus still yields one '0'.
	assign div_done  = (work_n == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_DIV;
						step_q  <= '0;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						cnt_q  <= cnt_q + 1'b1;
						step_q <= '0;
						if (div_done) begin
							state_q  <= ST_EMIT;
							rd_idx_q <= cnt_q[IDX_W-1:0];
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					rd_valid_s1 <= 1'b1;
					rd_last_s1  <= (rd_idx_q == '0);
					if (rd_idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the divider.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= DIV_W'(q_rdata.value);
			base_q <= q_rdata.base;
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			if (last_step) begin
				rem_q <= '0;
			end else begin
				rem_q <= rem_n;
			end
			work_q <= work_n;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			digit_store[cnt_q[IDX_W-1:0]] <= rem_n;
		end
		rd_digit_s1 <= digit_store[rd_idx_q];
	end

	assign result_valid = rd_valid_s1;
	assign last_digit   = rd_last_s1;
	assign digit_char   = to_ascii(rd_digit_s1);

endmodule
`default_nettype wire
